[rtl/core/mrul_pkg.sv]
// Package for the MRU list with wildcard increment matching.
// Holds the list depth, derived widths and the controller/datapath interface types.
// No dependencies.
package mrul_pkg;

    localparam int LIST_DEPTH = 8;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int VAL_W      = 16;
    localparam int POS_W      = 3;
    localparam int RIDX_W     = 3;
    localparam int COUNT_W    = 4;

    localparam logic MODE_TOUCH = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } mrul_cmd_t;

    typedef struct packed {
        logic scan_end;
    } mrul_sts_t;

endpackage

[rtl/core/mrul_ctrl.sv]
// Controller for the MRU list: sequences accept, scan and commit of one word.
// Depends on mrul_pkg.
module mrul_ctrl
    import mrul_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  mrul_sts_t sts,
    output mrul_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // the result register may be refilled once its word is taken
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                    state_next = S_DONE;
                else
                    cmd.step = 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_SCAN)
        else $error("accepted word did not start a scan");

    a_scan_end_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && sts.scan_end |=> state_reg == S_DONE)
        else $error("finished scan did not move to commit");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit did not present a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !cmd.commit)
        else $error("commit overwrote a waiting result");

endmodule

[rtl/core/mrul_dpath.sv]
// Datapath for the MRU list: entry registers, scan pointer, count and result registers.
// Depends on mrul_pkg; driven by mrul_ctrl commands.
module mrul_dpath
    import mrul_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mrul_cmd_t           cmd,
    output mrul_sts_t           sts,
    input  logic                mode,
    input  logic [VAL_W-1:0]    base_seconds,
    input  logic [VAL_W-1:0]    increment_seconds,
    input  logic                increment_known,
    input  logic [RIDX_W-1:0]   read_index,
    output logic                hit,
    output logic [POS_W-1:0]    hit_position,
    output logic                dropped,
    output logic [COUNT_W-1:0]  entry_count,
    output logic                read_valid,
    output logic [VAL_W-1:0]    read_base,
    output logic [VAL_W-1:0]    read_increment,
    output logic                read_known
);

    logic [VAL_W-1:0]   ent_base [LIST_DEPTH];
    logic [VAL_W-1:0]   ent_incr [LIST_DEPTH];
    logic               ent_known [LIST_DEPTH];

    logic [VAL_W-1:0]   base_reg;
    logic [VAL_W-1:0]   incr_reg;
    logic               known_reg;
    logic               read_op_reg;
    logic               rd_ok_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               hit_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               dropped_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic               rvalid_reg;
    logic [VAL_W-1:0]   rbase_reg;
    logic [VAL_W-1:0]   rincr_reg;
    logic               rknown_reg;

    logic [IDX_W-1:0]   ptr_idx;
    logic [VAL_W-1:0]   cur_base;
    logic [VAL_W-1:0]   cur_incr;
    logic               cur_known;
    logic               in_list;
    logic               match;
    logic               full;
    logic [CNT_W-1:0]   pos_sel;
    logic [CNT_W-1:0]   count_after;
    logic [VAL_W-1:0]   new_incr;
    logic               new_known;
    logic               touch_commit;

    assign ptr_idx   = ptr_reg[IDX_W-1:0];
    assign cur_base  = ent_base[ptr_idx];
    assign cur_incr  = ent_incr[ptr_idx];
    assign cur_known = ent_known[ptr_idx];
    assign in_list   = ptr_reg < count_reg;

    // an unknown increment on either side matches any stored increment
    assign match = in_list && (cur_base == base_reg)
                   && (!cur_known || !known_reg || (cur_incr == incr_reg));

    assign sts.scan_end = read_op_reg || !in_list || match;

    assign full        = (count_reg == CNT_W'(LIST_DEPTH));
    assign pos_sel     = match ? ptr_reg : (full ? CNT_W'(LIST_DEPTH - 1) : count_reg);
    assign count_after = (!match && !full) ? count_reg + 1'b1 : count_reg;

    // an unknown touch inherits the matched entry's increment
    assign new_incr  = known_reg ? incr_reg : (match ? cur_incr : '0);
    assign new_known = known_reg || (match && cur_known);

    assign touch_commit = cmd.commit && !read_op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            read_op_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                read_op_reg <= (mode == MODE_READ);
                ptr_reg     <= (mode == MODE_READ) ? CNT_W'(read_index) : '0;
            end
            else if (cmd.step)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (touch_commit)
                count_reg <= count_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg  <= base_seconds;
            incr_reg  <= increment_known ? increment_seconds : '0;
            known_reg <= increment_known;
            rd_ok_reg <= int'(read_index) < int'(count_reg);
        end
        if (cmd.commit)
        begin
            if (read_op_reg)
            begin
                hit_reg       <= 1'b0;
                pos_reg       <= '0;
                dropped_reg   <= 1'b0;
                count_out_reg <= COUNT_W'(count_reg);
                rvalid_reg    <= rd_ok_reg;
                rbase_reg     <= rd_ok_reg ? cur_base : '0;
                rincr_reg     <= rd_ok_reg ? cur_incr : '0;
                rknown_reg    <= rd_ok_reg && cur_known;
            end
            else
            begin
                hit_reg       <= match;
                pos_reg       <= POS_W'(pos_sel);
                dropped_reg   <= !match && full;
                count_out_reg <= COUNT_W'(count_after);
                rvalid_reg    <= 1'b0;
                rbase_reg     <= '0;
                rincr_reg     <= '0;
                rknown_reg    <= 1'b0;
            end
        end
    end

    // move to front: entries ahead of the chosen slot shift back one place
    always_ff @(posedge clk)
    begin
        if (touch_commit)
        begin
            for (int i = 1; i < LIST_DEPTH; i++)
            begin
                if (CNT_W'(i) <= pos_sel)
                begin
                    ent_base[i]  <= ent_base[i-1];
                    ent_incr[i]  <= ent_incr[i-1];
                    ent_known[i] <= ent_known[i-1];
                end
            end
            ent_base[0]  <= base_reg;
            ent_incr[0]  <= new_incr;
            ent_known[0] <= new_known;
        end
    end

    assign hit            = hit_reg;
    assign hit_position   = pos_reg;
    assign dropped        = dropped_reg;
    assign entry_count    = count_out_reg;
    assign read_valid     = rvalid_reg;
    assign read_base      = rbase_reg;
    assign read_increment = rincr_reg;
    assign read_known     = rknown_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    a_count_grows_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        touch_commit && !match && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("miss on a non-full list did not add one entry");

    a_read_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && read_op_reg |=> $stable(count_reg))
        else $error("read changed the entry count");

endmodule

[rtl/core/mru_list_with_wildcard_dedup_core.sv]
// Top level of the MRU list with wildcard increment matching.
// Instantiates mrul_ctrl and mrul_dpath; uses mrul_pkg.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------------
//   in      | in_valid / in_stall | mode, base_seconds, increment_seconds,
//           |                     | increment_known, read_index
//   out     | out_valid/out_stall | hit, hit_position, dropped, entry_count,
//           |                     | read_valid, read_base, read_increment, read_known
//
// After accept a word passes a scan state, then a commit state that registers its result; a
// read ends its scan at once; a touch scans until a hit or past the last stored entry,
// one entry compared a cycle. The next word can be taken as soon as a result is presented.
// Reset clears the entry count; entry registers are never read beyond the count.
// A stalled result holds in its register; the block takes a new word meanwhile and
// holds its commit until the result register is free.
module mru_list_with_wildcard_dedup_core
    import mrul_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [VAL_W-1:0]    base_seconds,
    input  logic [VAL_W-1:0]    increment_seconds,
    input  logic                increment_known,
    input  logic [RIDX_W-1:0]   read_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic [POS_W-1:0]    hit_position,
    output logic                dropped,
    output logic [COUNT_W-1:0]  entry_count,
    output logic                read_valid,
    output logic [VAL_W-1:0]    read_base,
    output logic [VAL_W-1:0]    read_increment,
    output logic                read_known
);

    mrul_cmd_t cmd;
    mrul_sts_t sts;

    mrul_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mrul_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .mode              (mode),
        .base_seconds      (base_seconds),
        .increment_seconds (increment_seconds),
        .increment_known   (increment_known),
        .read_index        (read_index),
        .hit               (hit),
        .hit_position      (hit_position),
        .dropped           (dropped),
        .entry_count       (entry_count),
        .read_valid        (read_valid),
        .read_base         (read_base),
        .read_increment    (read_increment),
        .read_known        (read_known)
    );

endmodule
